// ----- hdl/rpn_stack_evaluator_assert.svh -----
// Assertion macros for the reverse Polish evaluator controller.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpn assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpn assertion failed");

`endif

// ----- hdl/rpn_pkg.sv -----
// Package for the reverse Polish evaluator: sizes, opcodes, status codes,
// request and result types, and the controller to datapath signal groups.
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int PTR_W       = 7;
    localparam int OP_W        = 3;
    localparam int STAT_W      = 2;

    localparam logic [PTR_W-1:0] DEPTH_FULL = PTR_W'(STACK_DEPTH);

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] operand;
    } t_token;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [PTR_W-1:0]         stack_depth;
        logic [STAT_W-1:0]        status;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              cap;        // capture the operand of a new request
        logic              push;       // spill the top to memory, load the operand
        logic              rd;         // read the entry below the top
        logic              alu;        // combine the entry below with the top
        logic              pop;        // refill the top from memory, drop one entry
        logic              save;       // keep the current top for a pop result
        logic              report;     // load the result register
        logic              use_shown;  // result shows the saved top
        logic [OP_W-1:0]   alu_op;
        logic [STAT_W-1:0] status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic two;
    } t_dp_stat;

endpackage

// ----- hdl/rpn_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module rpn_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/rpn_dpath.sv -----
// Datapath of the reverse Polish evaluator: top-of-stack register, depth
// pointer, arithmetic unit and stack memory. Depends on rpn_pkg and rpn_ram.
module rpn_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [rpn_pkg::DATA_W-1:0] i_operand,
    input  rpn_pkg::t_dp_cmd  i_cmd,
    output rpn_pkg::t_dp_stat o_stat,
    output rpn_pkg::t_result  o_result
);
    import rpn_pkg::*;

    logic [PTR_W-1:0]  r_depth, n_depth;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_opnd;
    logic [DATA_W-1:0] r_shown;
    t_result           r_res;

    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_alu;
    logic [PTR_W-1:0]  w_dm1;
    logic [PTR_W-1:0]  w_dm2;

    // The memory holds every entry below the top; the top lives in r_top.
    assign w_dm1 = r_depth - PTR_W'(1);
    assign w_dm2 = r_depth - PTR_W'(2);

    rpn_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push && (r_depth != '0)),
        .i_waddr(w_dm1[ADDR_W-1:0]),
        .i_wdata(r_top),
        .i_re   (i_cmd.rd),
        .i_raddr(w_dm2[ADDR_W-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        case (i_cmd.alu_op)
            OP_ADD:  w_alu = w_rdata + r_top;
            OP_SUB:  w_alu = w_rdata - r_top;
            default: w_alu = w_rdata * r_top;
        endcase
    end

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        if (i_cmd.push) begin
            n_depth = r_depth + PTR_W'(1);
            n_top   = r_opnd;
        end else if (i_cmd.alu) begin
            n_depth = w_dm1;
            n_top   = w_alu;
        end else if (i_cmd.pop) begin
            n_depth = w_dm1;
            n_top   = w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
        r_top <= n_top;
        if (i_cmd.cap) begin
            r_opnd <= i_operand;
        end
        if (i_cmd.save) begin
            r_shown <= r_top;
        end
        if (i_cmd.report) begin
            r_res.stack_depth <= r_depth;
            r_res.status      <= i_cmd.status;
            if (i_cmd.use_shown) begin
                r_res.top_value <= r_shown;
            end else if (r_depth == '0) begin
                r_res.top_value <= '0;
            end else begin
                r_res.top_value <= r_top;
            end
        end
    end

    assign o_stat.empty = (r_depth == '0);
    assign o_stat.full  = (r_depth >= DEPTH_FULL);
    assign o_stat.two   = (r_depth >= PTR_W'(2));
    assign o_result     = r_res;

endmodule

// ----- hdl/rpn_ctrl.sv -----
// Controller of the reverse Polish evaluator: sequences each request through
// the datapath. Depends on rpn_pkg and the assertion macro header.
module rpn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [rpn_pkg::OP_W-1:0] i_opcode,
    input  rpn_pkg::t_dp_stat i_stat,
    output rpn_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import rpn_pkg::*;

    `include "rpn_stack_evaluator_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_REPORT
    } t_state;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_shown, n_shown;
    logic              r_done, n_done;
    t_dp_cmd           w_cmd;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_shown  = r_shown;
        n_done   = 1'b0;
        w_cmd    = '0;
        w_cmd.alu_op    = r_op;
        w_cmd.status    = r_status;
        w_cmd.use_shown = r_shown;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.cap = 1'b1;
                    n_op      = i_opcode;
                    n_status  = ST_OK;
                    n_shown   = 1'b0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_REPORT;
                case (r_op) inside
                    OP_PUSH: begin
                        if (i_stat.full) begin
                            n_status = ST_OVER;
                        end else begin
                            w_cmd.push = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL: begin
                        if (!i_stat.two) begin
                            n_status = ST_UNDER;
                        end else begin
                            w_cmd.rd = 1'b1;
                            n_state  = S_FETCH;
                        end
                    end
                    OP_POP: begin
                        if (i_stat.empty) begin
                            n_status = ST_UNDER;
                        end else begin
                            w_cmd.save = 1'b1;
                            n_shown    = 1'b1;
                            if (i_stat.two) begin
                                w_cmd.rd = 1'b1;
                                n_state  = S_FETCH;
                            end else begin
                                // Last entry: the top becomes meaningless and is masked.
                                w_cmd.pop = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FETCH: begin
                if (r_op == OP_POP) begin
                    w_cmd.pop = 1'b1;
                end else begin
                    w_cmd.alu = 1'b1;
                end
                n_state = S_REPORT;
            end
            S_REPORT: begin
                w_cmd.report = 1'b1;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_op     <= OP_PUSH;
            r_status <= ST_OK;
            r_shown  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_op     <= n_op;
            r_status <= n_status;
            r_shown  <= n_shown;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    `RPN_ASSERT_NEXT(a_start_exec, i_clk, i_rst_n, i_start && !o_busy, r_state == S_EXEC)
    `RPN_ASSERT_NEXT(a_report_done, i_clk, i_rst_n, r_state == S_REPORT, r_done)
    `RPN_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)
    `RPN_ASSERT_SAME(a_push_room, i_clk, i_rst_n, w_cmd.push, !i_stat.full)
    `RPN_ASSERT_SAME(a_alu_two, i_clk, i_rst_n, w_cmd.alu || w_cmd.rd, i_stat.two)

endmodule

// ----- hdl/rpn_stack_evaluator.sv -----
// Top level of the reverse Polish evaluator: joins the controller and the
// datapath. Depends on rpn_pkg, rpn_ctrl and rpn_dpath.
//
// Usage. A request (one token: opcode and operand in i_token) is taken at a
// rising clock edge where start is high and busy is low. Every request gives
// exactly one result on o_result, shown for a single cycle with o_valid high;
// the receiver cannot hold results off, so it must take each one as it comes.
// The result carries the top of stack after the step (or the popped value),
// the number of entries held, and a status of ok, underflow or overflow.
// A refused push or operation leaves the stack as it was.
//
// Sequencing. Push, no-operation, underflow, overflow and a pop of the last
// entry pass through the execute and report states; add, subtract, multiply
// and a pop with two or more entries also pass through a fetch state between
// them, as the registered read port of the stack memory supplies the entry
// below the top, held in a register. Busy stays high until the result is
// shown, so a request is not taken before the previous one is through.
// A new request may be taken in the same cycle as the previous result is shown.
//
// Reset (i_rst_n, synchronous, active low) empties the stack at once and
// clears the controller; the memory contents are not cleared and need not be.
module rpn_stack_evaluator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  rpn_pkg::t_token  i_token,
    output logic             busy,
    output logic             o_valid,
    output rpn_pkg::t_result o_result
);
    import rpn_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencing of each request.
    rpn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_opcode(i_token.opcode),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    // Stack storage, arithmetic and the result register.
    rpn_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_operand(i_token.operand),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

endmodule

// ----- bench/rpn_result_checker.sv -----
// Result checker for the reverse Polish evaluator bench: keeps its own operand stack,
// works out the report that each request should give and compares the reports the
// block produces. Depends on rpn_pkg.
module rpn_result_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  rpn_pkg::t_token  i_token,
    input  logic             i_valid,
    input  rpn_pkg::t_result i_result,
    output int               o_fail_count,
    output int               o_reports_due
);
    import rpn_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int                stack_fill;
    t_result           stack_reports_due [$];

    initial begin
        o_fail_count  = 0;
        o_reports_due = 0;
        stack_fill    = 0;
    end

    // Applies one token to the shadow stack and returns the report it should give.
    function automatic t_result apply_token(input t_token tok);
        t_result           rep;
        logic [DATA_W-1:0] upper;
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] shown;
        logic              popped;
        rep.status = ST_OK;
        popped     = 1'b0;
        shown      = '0;
        case (tok.opcode)
            OP_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    rep.status = ST_OVER;
                end else begin
                    stack_mem[stack_fill] = tok.operand;
                    stack_fill++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL: begin
                if (stack_fill < 2) begin
                    rep.status = ST_UNDER;
                end else begin
                    upper = stack_mem[stack_fill-1];
                    lower = stack_mem[stack_fill-2];
                    if (tok.opcode == OP_ADD)
                        stack_mem[stack_fill-2] = lower + upper;
                    else if (tok.opcode == OP_SUB)
                        stack_mem[stack_fill-2] = lower - upper;
                    else
                        stack_mem[stack_fill-2] = lower * upper;
                    stack_fill--;
                end
            end
            OP_POP: begin
                if (stack_fill == 0) begin
                    rep.status = ST_UNDER;
                end else begin
                    shown  = stack_mem[stack_fill-1];
                    popped = 1'b1;
                    stack_fill--;
                end
            end
            default: ;
        endcase
        if (!popped)
            shown = (stack_fill == 0) ? '0 : stack_mem[stack_fill-1];
        rep.top_value   = shown;
        rep.stack_depth = PTR_W'(stack_fill);
        return rep;
    endfunction

    function automatic void note_failure(input string why);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, why);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            stack_fill = 0;
            stack_reports_due.delete();
        end else begin
            if (i_valid !== 1'b0) begin
                if (stack_reports_due.size() == 0) begin
                    note_failure($sformatf({"report with no request outstanding:",
                                            " top %0d depth %0d status %0d"},
                                           i_result.top_value, i_result.stack_depth,
                                           i_result.status));
                end else begin
                    want = stack_reports_due.pop_front();
                    if (i_result.top_value !== want.top_value ||
                        i_result.stack_depth !== want.stack_depth ||
                        i_result.status !== want.status)
                        note_failure($sformatf({"mismatch: expected top %0d depth %0d status %0d,",
                                                " got top %0d depth %0d status %0d"},
                                               want.top_value, want.stack_depth, want.status,
                                               i_result.top_value, i_result.stack_depth,
                                               i_result.status));
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                fresh             = apply_token(i_token);
                stack_reports_due = {stack_reports_due, fresh};
            end
        end
        o_reports_due = stack_reports_due.size();
    end

endmodule

// ----- bench/tb_rpn_stack_evaluator.sv -----
// Top of the reverse Polish evaluator bench: clock, reset, request stimulus and verdict.
// Depends on rpn_pkg, rpn_stack_evaluator and rpn_result_checker.
module tb_rpn_stack_evaluator;
    import rpn_pkg::*;

    // Cycles with neither a request nor a report taken before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // This covers the longest request, so any straggling report is seen.
    localparam int SETTLE_CYCLES  = 8;

    // Opcodes five to seven have no name in the package; the block treats them as
    // no operation.
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // Request counts at which each idling phase ends.
    localparam int PHASE_ONE_END   = 185;
    localparam int PHASE_TWO_END   = 370;
    localparam int PHASE_THREE_END = 550;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_token  i_token;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    int fail_count;
    int reports_due;
    int idle_pct;
    int requests_sent;
    int stack_fill_seen;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    rpn_stack_evaluator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_token  (i_token),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    rpn_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_token       (i_token),
        .i_valid       (o_valid),
        .i_result      (o_result),
        .o_fail_count  (fail_count),
        .o_reports_due (reports_due)
    );

    // The watchdog restarts whenever a request or a report is taken. A hung
    // handshake or a lost report therefore ends the run as a failure.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rpn_stack_evaluator failed");
            $finish;
        end
    end

    // Depth that the stack should hold after a request; used only to shape the
    // stimulus, for instance to know how many pushes fill the stack.
    function automatic int next_fill(input logic [OP_W-1:0] op, input int fill);
        case (op)
            OP_PUSH:                return (fill < STACK_DEPTH) ? fill + 1 : fill;
            OP_ADD, OP_SUB, OP_MUL: return (fill >= 2) ? fill - 1 : fill;
            OP_POP:                 return (fill > 0) ? fill - 1 : fill;
            default:                return fill;
        endcase
    endfunction

    // Operands lean towards the edges of the signed range, where wrapping shows.
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return '1;
            4:       return DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_arith();
        case ($urandom_range(0, 2))
            0:       return OP_ADD;
            1:       return OP_SUB;
            default: return OP_MUL;
        endcase
    endfunction

    // Presents one request at a falling edge, after an optional idle gap, and holds
    // it until a rising edge finds busy low. Start is left high on return, so the
    // next call or the caller must deal with it at the following falling edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        t_token tok;
        tok.opcode  = op;
        tok.operand = value;
        @(negedge i_clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_token <= tok;
        do @(posedge i_clk); while (busy !== 1'b0);
        stack_fill_seen = next_fill(op, stack_fill_seen);
        requests_sent++;
    endtask

    // Holds the sender back until every outstanding report has come.
    task automatic settle_reports();
        @(negedge i_clk);
        start <= 1'b0;
        while (reports_due != 0) @(negedge i_clk);
    endtask

    // Pushes until the stack is full, then pushes into the full stack, which
    // must be refused with overflow, and finally combines the top two entries.
    task automatic fill_stack();
        while (stack_fill_seen < STACK_DEPTH)
            send_request(OP_PUSH, pick_operand());
        repeat ($urandom_range(1, 3))
            send_request(OP_PUSH, pick_operand());
        send_request(pick_arith(), pick_operand());
    endtask

    // Random part of one phase. Most of it is short well-formed expressions
    // (a few pushes followed by operations and now and then a pop), with whole
    // fill and drain runs to reach both ends of the stack, and some noise made
    // of arbitrary opcodes, the unused ones included.
    task automatic run_random(input int phase_end);
        int kind;
        int pushes;
        while (requests_sent < phase_end) begin
            kind = $urandom_range(0, 11);
            if (stack_fill_seen > 56 && kind <= 6)
                kind = 8;
            case (kind)
                7: fill_stack();
                8: begin
                    // Drain to empty, then pop and operate on nothing; wait for
                    // all reports afterwards so that the sender pauses now and then.
                    while (stack_fill_seen > 0)
                        send_request(OP_POP, pick_operand());
                    repeat ($urandom_range(1, 2))
                        send_request(OP_POP, pick_operand());
                    send_request(pick_arith(), pick_operand());
                    settle_reports();
                end
                9, 10, 11: begin
                    repeat ($urandom_range(1, 6))
                        send_request(OP_W'($urandom_range(0, 7)), pick_operand());
                end
                default: begin
                    pushes = $urandom_range(1, 4);
                    repeat (pushes)
                        send_request(OP_PUSH, pick_operand());
                    repeat ($urandom_range(0, pushes + 1))
                        send_request(pick_arith(), pick_operand());
                    if ($urandom_range(0, 3) == 0)
                        send_request(OP_POP, pick_operand());
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_token         = '0;
        idle_pct        = 18;
        requests_sent   = 0;
        stack_fill_seen = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. Pop and add on an empty stack must underflow and
        // show zero; an operation with a single entry underflows but shows it.
        send_request(OP_POP, 32'h1234_5678);
        send_request(OP_ADD, '1);
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_MUL, '0);
        // Largest positive plus one wraps to the most negative value.
        send_request(OP_PUSH, 32'h0000_0001);
        send_request(OP_ADD, '0);
        // Most negative minus itself, then minus one times the most negative.
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_SUB, '0);
        send_request(OP_PUSH, '1);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_MUL, '0);
        // Subtraction takes the deeper entry minus the top and wraps downwards.
        send_request(OP_PUSH, 32'h0000_0005);
        send_request(OP_SUB, '0);
        // The unused opcodes change nothing and report the current top.
        send_request(OP_SPARE_5, 32'hFFFF_0000);
        send_request(OP_SPARE_6, 32'h0000_FFFF);
        send_request(OP_SPARE_7, '1);
        // Pops with two entries and with the last one, then a no-operation on
        // the empty stack.
        send_request(OP_POP, '0);
        send_request(OP_POP, '0);
        send_request(OP_SPARE_7, '0);
        send_request(OP_PUSH, 32'hAAAA_AAAA);
        send_request(OP_PUSH, 32'h5555_5555);
        send_request(OP_MUL, '0);
        send_request(OP_SUB, '0);
        send_request(OP_POP, '0);
        settle_reports();

        // A full stack early on, so that overflow is seen whatever the seed.
        fill_stack();
        run_random(PHASE_ONE_END);
        settle_reports();

        idle_pct = 46;
        run_random(PHASE_TWO_END);
        settle_reports();

        idle_pct = 0;
        run_random(PHASE_THREE_END);
        settle_reports();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && reports_due == 0)
            $display("tb_rpn_stack_evaluator passed");
        else
            $display("tb_rpn_stack_evaluator failed");
        $finish;
    end

endmodule
